[design/circular_deque_with_search_top_defines.svh]
// ============================================================================
// Assertion macros for the deque with search
// Shared helpers that keep the checker's assertions short and uniform.
// ============================================================================
`ifndef CIRCULAR_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDQS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

[design/cdqs_pkg.sv]
// ============================================================================
// Deque with search package
// Request and status codes, cell command types and controller states.
// ============================================================================
package cdqs_pkg;

    // Default number of list entries.
    localparam int DEPTH_DEF = 16;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    // A search reports at most this many matches.
    localparam int RESULT_SLOTS = 16;
    localparam int MATCH_W      = $clog2(RESULT_SLOTS + 1);

    // Request codes.
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // What each cell does with its stored value.
    typedef enum logic [1:0] {
        DATA_HOLD,
        DATA_LOAD,
        DATA_SHIFT_R,
        DATA_SHIFT_L
    } data_cmd_t;

    // What each cell does with its match flag.
    typedef enum logic [1:0] {
        FLAG_HOLD,
        FLAG_CAPTURE,
        FLAG_SHIFT
    } flag_cmd_t;

    typedef struct packed {
        data_cmd_t data;
        flag_cmd_t flag;
    } cell_cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

[design/circular_deque_with_search_top.sv]
// ============================================================================
// Deque with linear search
// Ordered list of up to DEPTH signed 32-bit values with front and back insert
// and delete, and a search that reports every matching position.
// ============================================================================
// The list lives in a row of DEPTH cells, front at cell 0. Inserts and
// deletes each give one result. A search compares every cell at once, then
// moves the match flags one cell per cycle toward the front while the
// result side is not stalled; no new request is taken until the search
// closes. A search reports at most 16 matches, the first ones from the front.
module circular_deque_with_search_top
    import cdqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [POS_W-1:0]          m_position,
    output logic                      m_is_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_cmd_t                 cell_cmd;
    logic [CNT_W-1:0]          entry_count;
    logic signed [VALUE_W-1:0] cell_data [DEPTH];
    logic                      cell_flag [DEPTH];

    // Request decode, search sequencing and result register.
    cdqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_position  (m_position),
        .m_is_last   (m_is_last),
        .flag_head   (cell_flag[0]),
        .entry_count (entry_count),
        .cell_cmd    (cell_cmd)
    );

    // Row of cells; data moves either way, flags move toward the front.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_data;
        logic signed [VALUE_W-1:0] right_data;
        logic                      right_flag;

        if (i == 0) begin : g_head
            assign left_data = s_value;
        end else begin : g_body
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data = '0;
            assign right_flag = 1'b0;
        end else begin : g_inner
            assign right_data = cell_data[i+1];
            assign right_flag = cell_flag[i+1];
        end

        cdqs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cell_cmd),
            .key        (s_value),
            .left_data  (left_data),
            .right_data (right_data),
            .right_flag (right_flag),
            .load_here  (CNT_W'(i) == entry_count),
            .live       (CNT_W'(i) < entry_count),
            .data_out   (cell_data[i]),
            .flag_out   (cell_flag[i])
        );
    end

endmodule

[design/cdqs_cell.sv]
// ============================================================================
// Deque cell
// Holds one list entry and its search match flag, and trades both with its
// neighbors on command from the controller.
// ============================================================================
module cdqs_cell
    import cdqs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_cmd_t                 cmd,
    input  logic signed [VALUE_W-1:0] key,
    input  logic signed [VALUE_W-1:0] left_data,
    input  logic signed [VALUE_W-1:0] right_data,
    input  logic                      right_flag,
    input  logic                      load_here,
    input  logic                      live,
    output logic signed [VALUE_W-1:0] data_out,
    output logic                      flag_out
);

    logic signed [VALUE_W-1:0] data_reg, data_next;
    logic                      flag_reg, flag_next;

    // Next stored value: keep, load the request value, or take a neighbor's.
    always_comb begin
        data_next = data_reg;
        case (cmd.data)
            DATA_LOAD:    if (load_here) data_next = key;
            DATA_SHIFT_R: data_next = left_data;
            DATA_SHIFT_L: data_next = right_data;
            default:      data_next = data_reg;
        endcase
    end

    // Next flag: compare against the key, or move toward the front.
    always_comb begin
        flag_next = flag_reg;
        case (cmd.flag)
            FLAG_CAPTURE: flag_next = live && (data_reg == key);
            FLAG_SHIFT:   flag_next = right_flag;
            default:      flag_next = flag_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else begin
            flag_reg <= flag_next;
        end
    end

    assign data_out = data_reg;
    assign flag_out = flag_reg;

endmodule

[design/cdqs_ctrl.sv]
// ============================================================================
// Deque controller
// Decodes requests, keeps the entry count, steps the match flags through the
// cell row during a search and drives the result register.
// ============================================================================
module cdqs_ctrl
    import cdqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [OP_W-1:0]                  s_op,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [STATUS_W-1:0]              m_status,
    output logic [POS_W-1:0]                 m_position,
    output logic                             m_is_last,
    input  logic                             flag_head,
    output logic [$clog2(DEPTH+1)-1:0]       entry_count,
    output cell_cmd_t                        cell_cmd
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [MATCH_W-1:0]   match_reg, match_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]     pend_pos_reg, pend_pos_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [POS_W-1:0]     m_position_reg, m_position_next;
    logic                 m_is_last_reg, m_is_last_next;

    logic             out_free;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W-1:0] cur_pos;
    logic             at_end;
    logic             emit;
    logic [STATUS_W-1:0] emit_status;
    logic [CNT_W-1:0] emit_pos;
    logic             emit_last;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign cur_pos  = scan_reg + CNT_W'(1);
    assign at_end   = (cur_pos == count_reg);

    // Request decode and search sequencing.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        match_next      = match_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        cell_cmd.data   = DATA_HOLD;
        cell_cmd.flag   = FLAG_HOLD;
        emit            = 1'b0;
        emit_status     = STAT_DONE;
        emit_pos        = '0;
        emit_last       = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_INS_FRONT, OP_INS_BACK: begin
                            emit = 1'b1;
                            if (is_full) begin
                                emit_status = STAT_OVERFLOW;
                            end else begin
                                cell_cmd.data = (s_op == OP_INS_FRONT) ? DATA_SHIFT_R
                                                                       : DATA_LOAD;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                emit_status = STAT_UNDERFLOW;
                            end else begin
                                if (s_op == OP_DEL_FRONT) begin
                                    cell_cmd.data = DATA_SHIFT_L;
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (is_empty) begin
                                emit        = 1'b1;
                                emit_status = STAT_NOT_FOUND;
                            end else begin
                                cell_cmd.flag   = FLAG_CAPTURE;
                                state_next      = ST_SCAN;
                                scan_next       = '0;
                                match_next      = '0;
                                pend_valid_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // One cell per cycle reaches the head while the result side is free; a match
            // is held back until the next one shows whether it was the last.
            ST_SCAN: begin
                if (out_free) begin
                    cell_cmd.flag = FLAG_SHIFT;
                    scan_next     = cur_pos;
                    if (flag_head) begin
                        if (pend_valid_reg) begin
                            emit      = 1'b1;
                            emit_pos  = pend_pos_reg;
                            emit_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pos_next   = cur_pos;
                        match_next      = match_reg + MATCH_W'(1);
                        if (at_end || (match_next == MATCH_W'(RESULT_SLOTS))) begin
                            state_next = ST_FLUSH;
                        end
                    end else if (at_end) begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            // Close the search with the held match or a not-found result.
            ST_FLUSH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_valid_reg) begin
                        emit_pos = pend_pos_reg;
                    end else begin
                        emit_status = STAT_NOT_FOUND;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Result register.
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_position_next = m_position_reg;
        m_is_last_next  = m_is_last_reg;
        if (emit) begin
            m_valid_next    = 1'b1;
            m_status_next   = emit_status;
            m_position_next = POS_W'(emit_pos);
            m_is_last_next  = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            scan_reg       <= '0;
            match_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            scan_reg       <= scan_next;
            match_reg      <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_pos_reg   <= pend_pos_next;
        m_status_reg   <= m_status_next;
        m_position_reg <= m_position_next;
        m_is_last_reg  <= m_is_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_position  = m_position_reg;
    assign m_is_last   = m_is_last_reg;
    assign entry_count = count_reg;

endmodule

[design/cdqs_checker.sv]
// ============================================================================
// Deque port checker
// Watches the top level's ports for result ordering and field consistency.
// ============================================================================
`include "circular_deque_with_search_top_defines.svh"

module cdqs_checker
    import cdqs_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [STATUS_W-1:0]       m_status,
    input logic [POS_W-1:0]          m_position,
    input logic                      m_is_last
);

    // A stalled result keeps its fields.
    `CDQS_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_position) && $stable(m_is_last))

    // Only search matches may be followed by more results of the same request.
    `CDQS_ASSERT_SAME(a_last_unless_found, aclk, aresetn, m_valid && (m_status != STAT_DONE), m_is_last)

    // Status-only results carry no position.
    `CDQS_ASSERT_SAME(a_pos_zero, aclk, aresetn, m_valid && (m_status != STAT_DONE), m_position == '0)

    // While a search still has results to give, no new request is taken.
    `CDQS_ASSERT_SAME(a_busy_mid_search, aclk, aresetn, m_valid && !m_is_last, !s_ready)

endmodule

bind circular_deque_with_search_top cdqs_checker u_cdqs_checker (.*);

[dv/circular_deque_with_search_top_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// Deque with search testbench
// Drives insert, delete and search requests through the valid/ready channel,
// predicts every result from a private copy of the list and checks each
// result field by field, with random idling on both sides.
// ============================================================================
module circular_deque_with_search_top_test;
    import cdqs_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        bit                        hold;   // wait for all results before sending
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic                is_last;
    } result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op = OP_INS_FRONT;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [STATUS_W-1:0]       m_status;
    logic [POS_W-1:0]          m_position;
    logic                      m_is_last;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       mismatch_count = 0;
    int       sent_count = 0;
    int       rx_cycle = 0;
    logic     all_results_in = 1'b1;

    // Private copy of the list.
    logic signed [VALUE_W-1:0] list_ring[LIST_DEPTH];
    int                        head_slot;
    int                        live_count;

    circular_deque_with_search_top #(.DEPTH(LIST_DEPTH)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_position (m_position),
        .m_is_last  (m_is_last)
    );

    always #4 aclk = ~aclk;

    task automatic add_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                               input bit hold);
        request_t req;
        req.op = op;
        req.value = value;
        req.hold = hold;
        pending_requests.push_back(req);
    endtask

    task automatic expect_result(input logic [STATUS_W-1:0] status, input int position,
                                 input logic is_last);
        result_t res;
        res.status = status;
        res.position = POS_W'(position);
        res.is_last = is_last;
        expected_results.push_back(res);
    endtask

    // Apply one accepted request to the private list and queue its results.
    task automatic apply_deque_request(input logic [OP_W-1:0] op,
                                       input logic signed [VALUE_W-1:0] value);
        int hits;
        hits = 0;
        case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (live_count >= LIST_DEPTH) begin
                    expect_result(STAT_OVERFLOW, 0, 1'b1);
                end else begin
                    if (op == OP_INS_FRONT) begin
                        head_slot = (head_slot + LIST_DEPTH - 1) % LIST_DEPTH;
                        list_ring[head_slot] = value;
                    end else begin
                        list_ring[(head_slot + live_count) % LIST_DEPTH] = value;
                    end
                    live_count++;
                    expect_result(STAT_DONE, 0, 1'b1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
                if (live_count == 0) begin
                    expect_result(STAT_UNDERFLOW, 0, 1'b1);
                end else begin
                    if (op == OP_DEL_FRONT) head_slot = (head_slot + 1) % LIST_DEPTH;
                    live_count--;
                    expect_result(STAT_DONE, 0, 1'b1);
                end
            end
            OP_SEARCH: begin
                // Report matches from the front, at most one slot set's worth.
                for (int i = 0; i < live_count && hits < RESULT_SLOTS; i++) begin
                    if (list_ring[(head_slot + i) % LIST_DEPTH] == value) begin
                        expect_result(STAT_DONE, i + 1, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0) begin
                    expect_result(STAT_NOT_FOUND, 0, 1'b1);
                end else begin
                    expected_results[expected_results.size() - 1].is_last = 1'b1;
                end
            end
            default: ;  // unused codes are dropped without a result
        endcase
    endtask

    // Request driver: presents queued requests with random gaps.
    always @(posedge aclk) begin
        request_t req;
        logic     gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) sent_count++;
            gap = !(sent_count >= 40 && sent_count < 90) && ($urandom_range(0, 99) < 10);
            if (pending_requests.size() != 0 && !gap &&
                (!pending_requests[0].hold || (!s_valid && all_results_in))) begin
                req = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_op <= req.op;
                s_value <= req.value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side stalls at random, except for one quiet stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            m_ready <= (rx_cycle >= 200 && rx_cycle < 700) || ($urandom_range(0, 99) >= 10);
        end
    end

    // Monitor: predicts on each accepted request, then checks each result.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            head_slot = 0;
            live_count = 0;
            all_results_in <= 1'b1;
        end else begin
            if (s_valid && s_ready) apply_deque_request(s_op, s_value);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d position=%0d is_last=%0d",
                             $time, m_status, m_position, m_is_last);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        mismatch_count++;
                    end
                    if (m_position !== want.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, m_position);
                        mismatch_count++;
                    end
                    if (m_is_last !== want.is_last) begin
                        $display("%0t: is_last expected %0d actual %0d",
                                 $time, want.is_last, m_is_last);
                        mismatch_count++;
                    end
                end
            end
            all_results_in <= (expected_results.size() == 0);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [VALUE_W-1:0] pool[3];
        int                 pool_size;
        int                 random_count;
        int                 episode;
        int                 kind;
        int                 length;
        int                 roll;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;

        // Directed: empty list cases, extreme values, ignored codes, drain.
        add_request(OP_SEARCH, 32'h0000_0000, 1'b0);
        add_request(OP_DEL_FRONT, 32'hFFFF_FFFF, 1'b0);
        add_request(OP_DEL_BACK, 32'h0000_0000, 1'b0);
        add_request(OP_INS_FRONT, 32'h8000_0000, 1'b0);
        add_request(OP_INS_BACK, 32'h7FFF_FFFF, 1'b0);
        add_request(OP_INS_FRONT, 32'hFFFF_FFFF, 1'b0);
        add_request(OP_INS_BACK, 32'h0000_0000, 1'b0);
        add_request(OP_INS_BACK, 32'h8000_0000, 1'b0);
        add_request(OP_SEARCH, 32'h8000_0000, 1'b0);
        add_request(OP_SEARCH, 32'h7FFF_FFFF, 1'b0);
        add_request(OP_SEARCH, 32'h5555_AAAA, 1'b0);
        add_request(3'd5, 32'hAAAA_AAAA, 1'b0);
        add_request(3'd6, 32'h5555_5555, 1'b0);
        add_request(3'd7, 32'hFFFF_FFFF, 1'b0);
        add_request(OP_SEARCH, 32'hFFFF_FFFF, 1'b1);
        add_request(OP_DEL_FRONT, 32'h0000_0000, 1'b0);
        add_request(OP_DEL_BACK, 32'h0000_0000, 1'b0);
        add_request(OP_DEL_BACK, 32'h0000_0000, 1'b0);
        add_request(OP_DEL_FRONT, 32'h0000_0000, 1'b0);
        add_request(OP_DEL_FRONT, 32'h0000_0000, 1'b0);
        add_request(OP_DEL_BACK, 32'h0000_0000, 1'b0);

        // Random episodes that grow, shrink or churn the list. Values come
        // mostly from a small pool so that searches find several matches.
        // The first episode fills the list with one value and overflows it.
        random_count = 0;
        episode = 0;
        while (random_count < 95) begin
            kind = (episode == 0) ? 0 : $urandom_range(0, 2);
            length = (episode == 0) ? 19 : $urandom_range(6, 20);
            pool_size = (episode == 0 || $urandom_range(0, 2) == 0) ? 1 : 3;
            for (int j = 0; j < 3; j++) pool[j] = $urandom;
            for (int k = 0; k < length; k++) begin
                roll = $urandom_range(0, 99);
                value = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, pool_size - 1)]
                                                     : $urandom;
                if (episode == 0) begin
                    op = (k < 18) ? ($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK)
                                  : OP_SEARCH;
                    value = pool[0];
                end else if (roll < 3) begin
                    op = OP_W'($urandom_range(5, 7));
                end else begin
                    roll = $urandom_range(0, 99);
                    case (kind)
                        0: op = (roll < 70) ? OP_INS_FRONT : (roll < 80) ? OP_DEL_FRONT
                                                                         : OP_SEARCH;
                        1: op = (roll < 10) ? OP_INS_FRONT : (roll < 80) ? OP_DEL_FRONT
                                                                         : OP_SEARCH;
                        default: op = (roll < 30) ? OP_INS_FRONT
                                      : (roll < 60) ? OP_DEL_FRONT : OP_SEARCH;
                    endcase
                    // Pick the end of the list at random.
                    if (op != OP_SEARCH && $urandom_range(0, 1) == 1) op = op + 1'b1;
                end
                add_request(op, value, (k == 0 && episode % 4 == 3));
                if (op <= OP_SEARCH) random_count++;
            end
            episode++;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        // Keep watching so that any unexpected late result is still counted.
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
